FILE: rtl/dscf_pkg.sv
// Shared types and constants for the decimated snapshot CSV formatter.
package dscf_pkg;

    // ASCII codes used on the line
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Thousandths saturate at 9999.999
    localparam logic [23:0] MAX_THOU = 24'd9999999;
    // Seven decimal digits: four integer, three fraction
    localparam int NUM_DIGITS = 7;

    // Byte selector from controller to datapath
    typedef enum logic [2:0] {
        SEL_MINUS,
        SEL_DIGIT,
        SEL_POINT,
        SEL_COMMA,
        SEL_CR,
        SEL_LF
    } byte_sel_t;

    // Controller commands
    typedef struct packed {
        logic      load_value;  // latch the selected snapshot entry for scaling
        logic      scale;       // register the scaled magnitude
        logic      convert;     // start digit conversion
        logic      digit_step;  // one double-dabble shift
        logic      emit;        // load output register
        byte_sel_t sel;
        logic [2:0] digit_idx;  // 0 = most significant of seven
        logic      last;
    } dp_cmd_t;

    // Datapath status
    typedef struct packed {
        logic       neg;        // value negative and nonzero after rounding
        logic [2:0] first_digit; // index of first printed integer digit
    } dp_stat_t;

endpackage

FILE: rtl/dscf_datapath.sv
// Datapath: snapshot store, scaling, BCD conversion and output byte register.
module dscf_datapath
    import dscf_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int NUM_VALUES = 4,
    parameter int IDX_W      = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1
)
(
    input  logic                 clk,
    input  logic                 store,
    input  logic [127:0]         samples,
    input  logic [IDX_W-1:0]     value_idx,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [7:0]           byte_out
);

    logic [31:0]   snap_reg [NUM_VALUES];
    logic [31:0]   mag_reg;
    logic          sign_reg;
    logic [23:0]   thou_reg;
    logic [23:0]   shift_reg;
    logic [27:0]   bcd_reg;
    logic [41:0]   prod;
    logic [42:0]   rounded;
    logic [42:0]   tval;
    logic [27:0]   bcd_adj;
    logic [2:0]    first_c;

    // Snapshot capture; entries past the four sample fields hold zero
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                snap_reg[i] <= (i < 4) ? samples[32*(i%4) +: 32] : 32'd0;
            end
        end
    end

    // Magnitude times 1000, rounded half away from zero
    assign prod    = {10'd0, mag_reg} * 42'd1000;
    assign rounded = {1'b0, prod} + ((43'd1 << FRAC_BITS) >> 1);
    assign tval    = rounded >> FRAC_BITS;

    // Double-dabble adjust of all seven digits
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5)
                ? bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    // First nonzero integer digit, units always printed
    always_comb
    begin
        first_c = 3'd3;
        for (int d = 2; d >= 0; d--)
        begin
            if (bcd_reg[4*(6-d) +: 4] != 4'd0)
            begin
                first_c = 3'(d);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_value)
        begin
            sign_reg <= snap_reg[value_idx][31];
            mag_reg  <= snap_reg[value_idx][31] ? (~snap_reg[value_idx] + 32'd1)
                                                : snap_reg[value_idx];
        end
        if (cmd.scale)
        begin
            thou_reg <= (tval > {19'd0, MAX_THOU}) ? MAX_THOU : tval[23:0];
        end
        if (cmd.convert)
        begin
            shift_reg <= thou_reg;
            bcd_reg   <= '0;
        end
        else if (cmd.digit_step)
        begin
            bcd_reg   <= {bcd_adj[26:0], shift_reg[23]};
            shift_reg <= {shift_reg[22:0], 1'b0};
        end
        if (cmd.emit)
        begin
            case (cmd.sel)
                SEL_MINUS: byte_out <= CH_MINUS;
                SEL_DIGIT: byte_out <= CH_ZERO
                    + {4'd0, bcd_reg[4*(6-cmd.digit_idx) +: 4]};
                SEL_POINT: byte_out <= CH_POINT;
                SEL_COMMA: byte_out <= CH_COMMA;
                SEL_CR:    byte_out <= CH_CR;
                SEL_LF:    byte_out <= CH_LF;
                default:   byte_out <= CH_ZERO;
            endcase
        end
    end

    assign stat.neg         = sign_reg && (thou_reg != 24'd0);
    assign stat.first_digit = first_c;

endmodule

FILE: rtl/dscf_ctrl.sv
// Controller: prescaler, pending flag, drop counter and line sequencer.
module dscf_ctrl
    import dscf_pkg::*;
#(
    parameter int NUM_VALUES = 4,
    parameter int IDX_W      = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    output logic             store,
    output logic [IDX_W-1:0] value_idx,
    output dp_cmd_t          cmd,
    input  dp_stat_t         stat,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_last,
    output logic [15:0]      drop_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SCALE, S_CONV, S_STEP, S_SIGN,
        S_DIGIT, S_POINT, S_FRAC, S_SEP, S_CR, S_LF, S_WAIT
    } state_t;

    state_t           state_reg, state_next, after_reg;
    logic [15:0]      div_reg;
    logic [15:0]      presc_reg;
    logic             pending_reg;
    logic [15:0]      drop_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [4:0]       cnt_reg;
    logic [2:0]       dig_reg;
    logic             valid_reg;
    logic             last_reg;
    logic [15:0]      div_eff;
    logic [15:0]      presc_inc;
    logic             take;
    logic             busy_out;

    assign div_eff   = (div_reg == 16'd0) ? 16'd1 : div_reg;
    assign presc_inc = presc_reg + 16'd1;
    assign in_ready  = (state_reg == S_IDLE);
    assign take      = in_valid && in_ready;
    assign busy_out  = valid_reg && !out_ready;
    assign store     = take && !in_cmd && (presc_inc >= div_eff) && !pending_reg;
    assign value_idx = idx_reg;
    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign drop_count = drop_reg;

    // Command decode per state
    always_comb
    begin
        cmd = '0;
        cmd.digit_idx = dig_reg;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = (take && in_cmd && pending_reg) ? S_LOAD : S_IDLE;
            S_LOAD:  begin cmd.load_value = 1'b1; state_next = S_SCALE; end
            S_SCALE: begin cmd.scale = 1'b1; state_next = S_CONV; end
            S_CONV:  begin cmd.convert = 1'b1; state_next = S_STEP; end
            S_STEP:  begin cmd.digit_step = 1'b1;
                         state_next = (cnt_reg == 5'd23) ? S_SIGN : S_STEP; end
            S_SIGN:  state_next = S_DIGIT;
            S_DIGIT, S_FRAC: begin cmd.sel = SEL_DIGIT; end
            S_POINT: begin cmd.sel = SEL_POINT; end
            S_SEP:   begin cmd.sel = SEL_COMMA; end
            S_CR:    begin cmd.sel = SEL_CR; end
            S_LF:    begin cmd.sel = SEL_LF; cmd.last = 1'b1; end
            S_WAIT:  state_next = busy_out ? S_WAIT : after_reg;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SIGN)
        begin
            cmd.sel = SEL_MINUS;
        end
        cmd.emit = !busy_out && ((state_reg == S_SIGN && stat.neg)
            || state_reg == S_DIGIT || state_reg == S_POINT
            || state_reg == S_FRAC || state_reg == S_SEP
            || state_reg == S_CR || state_reg == S_LF);
    end

    // State, control registers and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            after_reg   <= S_IDLE;
            div_reg     <= 16'd1;
            presc_reg   <= '0;
            pending_reg <= 1'b0;
            drop_reg    <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            dig_reg     <= '0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                div_reg <= cfg_data;
            end
            if (valid_reg && out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
                last_reg  <= cmd.last;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take && !in_cmd)
                    begin
                        if (presc_inc < div_eff)
                        begin
                            presc_reg <= presc_inc;
                        end
                        else
                        begin
                            presc_reg <= '0;
                            if (pending_reg)
                            begin
                                if (drop_reg != 16'hFFFF)
                                begin
                                    drop_reg <= drop_reg + 16'd1;
                                end
                            end
                            else
                            begin
                                pending_reg <= 1'b1;
                            end
                        end
                    end
                    idx_reg <= '0;
                    state_reg <= state_next;
                end
                S_CONV:
                begin
                    cnt_reg   <= '0;
                    state_reg <= state_next;
                end
                S_STEP:
                begin
                    cnt_reg   <= cnt_reg + 5'd1;
                    state_reg <= state_next;
                end
                S_SIGN:
                begin
                    if (!busy_out)
                    begin
                        dig_reg   <= stat.first_digit;
                        state_reg <= stat.neg ? S_WAIT : S_DIGIT;
                        after_reg <= S_DIGIT;
                    end
                end
                S_DIGIT, S_POINT, S_FRAC, S_SEP, S_CR:
                begin
                    if (!busy_out)
                    begin
                        state_reg <= S_WAIT;
                        case (state_reg)
                            S_DIGIT:
                            begin
                                dig_reg   <= dig_reg + 3'd1;
                                after_reg <= (dig_reg == 3'd3) ? S_POINT : S_DIGIT;
                            end
                            S_POINT: after_reg <= S_FRAC;
                            S_FRAC:
                            begin
                                dig_reg <= dig_reg + 3'd1;
                                if (dig_reg != 3'd6)
                                begin
                                    after_reg <= S_FRAC;
                                end
                                else if (idx_reg == IDX_W'(NUM_VALUES - 1))
                                begin
                                    after_reg <= S_CR;
                                end
                                else
                                begin
                                    after_reg <= S_SEP;
                                end
                            end
                            S_SEP:
                            begin
                                idx_reg   <= idx_reg + 1'b1;
                                after_reg <= S_LOAD;
                            end
                            default: after_reg <= S_LF;
                        endcase
                    end
                end
                S_LF:
                begin
                    if (!busy_out)
                    begin
                        pending_reg <= 1'b0;
                        after_reg   <= S_IDLE;
                        state_reg   <= S_WAIT;
                    end
                end
                default: state_reg <= state_next;
            endcase
        end
    end

    // The line is only emitted while a snapshot is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> pending_reg)
        else $error("line start without pending snapshot");
    // No input is taken while a line is being built
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input ready while busy");
    // Drop counter never wraps
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(drop_reg) == 16'hFFFF) |-> (drop_reg == 16'hFFFF))
        else $error("drop counter wrapped");

endmodule

FILE: rtl/decimated_snapshot_csv_formatter_unit.sv
// Top level of the decimated snapshot CSV formatter.
// Capture transactions (tuser = 0) are taken back to back while idle; a kept
// tick stores the four Q16.16 samples as a snapshot, a kept tick arriving while
// one is pending bumps a saturating drop counter. A service transaction
// (tuser = 1) with a snapshot pending emits one CSV line of up to 41 bytes.
// Each value first passes through loading, scaling and clearing the shared
// converter, then 24 one-bit BCD shift steps, then a sign state that picks the
// sign (and sends the minus when there is one). Each byte passes through the
// output register and waits there while the sink stalls. No input is taken
// until the line's final LF has been accepted.
module decimated_snapshot_csv_formatter_unit
    import dscf_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int NUM_VALUES = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,       // update_div
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,        // sample_a, sample_b, sample_c, sample_d
    input  logic         s_tuser,        // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,        // out_byte, dropped_frames
    output logic         m_tlast
);

    localparam int IDX_W = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;

    logic             store;
    logic [IDX_W-1:0] value_idx;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [7:0]       byte_out;
    logic [15:0]      drop_count;

    dscf_ctrl #(.NUM_VALUES(NUM_VALUES)) u_ctrl (
        .clk, .rst_n, .cfg_we, .cfg_data,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser),
        .store, .value_idx, .cmd, .stat,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .drop_count
    );

    dscf_datapath #(.FRAC_BITS(FRAC_BITS), .NUM_VALUES(NUM_VALUES)) u_dp (
        .clk, .store, .samples(s_tdata), .value_idx, .cmd, .stat,
        .byte_out
    );

    assign m_tdata = {drop_count, byte_out};

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the decimated snapshot CSV formatter: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_top;
    import dscf_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    typedef struct packed {
        logic [7:0]  ch;
        logic        lf_end;
        logic [15:0] drops;
    } csv_byte_t;

    typedef struct {
        logic        cmd;
        logic [31:0] smp [4];
        int          n_want;     // -1: predictor only
        logic [7:0]  want [4];   // leading bytes typed in
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         m_tlast;

    // Predictor state
    logic [15:0] div_reg;
    logic [15:0] prescale;
    logic        snap_pending;
    logic [31:0] snap [4];
    logic [15:0] drop_cnt;

    csv_byte_t   line_q [$];
    logic [7:0]  typed_q [$];
    int          err_cnt;
    longint      cyc = 0;
    bit          stall_en;

    decimated_snapshot_csv_formatter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Append one formatted value as thousandths text
    function automatic void push_value(logic [31:0] raw);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] thou;
        int          ip;
        int          fp;
        int          nd;
        logic [7:0]  dg [8];
        neg  = raw[31];
        mag  = neg ? {32'd0, -raw} : {32'd0, raw};
        thou = (mag * 1000 + 64'd32768) >> 16;
        if (thou > 64'(MAX_THOU))
            thou = 64'(MAX_THOU);
        if (neg && thou != 0)
            line_q.push_back('{CH_MINUS, 1'b0, drop_cnt});
        ip = int'(thou / 1000);
        fp = int'(thou % 1000);
        nd = 0;
        do
        begin
            dg[nd] = CH_ZERO + 8'(ip % 10);
            ip = ip / 10;
            nd++;
        end
        while (ip != 0);
        for (int i = nd - 1; i >= 0; i--)
            line_q.push_back('{dg[i], 1'b0, drop_cnt});
        line_q.push_back('{CH_POINT, 1'b0, drop_cnt});
        line_q.push_back('{CH_ZERO + 8'(fp / 100), 1'b0, drop_cnt});
        line_q.push_back('{CH_ZERO + 8'((fp / 10) % 10), 1'b0, drop_cnt});
        line_q.push_back('{CH_ZERO + 8'(fp % 10), 1'b0, drop_cnt});
    endfunction

    // Advance the predictor by one accepted input transaction
    function automatic void predict_item(logic cmd, logic [127:0] data);
        logic [15:0] eff_div;
        eff_div = (div_reg == 0) ? 16'd1 : div_reg;
        if (cmd == CMD_TICK)
        begin
            prescale = prescale + 16'd1;
            if (prescale >= eff_div)
            begin
                prescale = 16'd0;
                if (snap_pending)
                begin
                    if (drop_cnt != 16'hFFFF)
                        drop_cnt = drop_cnt + 16'd1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        snap[i] = data[32*i +: 32];
                    snap_pending = 1'b1;
                end
            end
        end
        else if (snap_pending)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (i > 0)
                    line_q.push_back('{CH_COMMA, 1'b0, drop_cnt});
                push_value(snap[i]);
            end
            line_q.push_back('{CH_CR, 1'b0, drop_cnt});
            line_q.push_back('{CH_LF, 1'b1, drop_cnt});
            snap_pending = 1'b0;
        end
    endfunction

    // Output checker
    always @(posedge clk)
    begin
        csv_byte_t exp_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_q.size() == 0)
            begin
                $error("unexpected output byte %h", m_tdata[7:0]);
                err_cnt++;
            end
            else
            begin
                exp_b = line_q.pop_front();
                if (typed_q.size() != 0)
                begin
                    if (typed_q[0] != m_tdata[7:0])
                    begin
                        $error("out_byte (table) exp %h got %h", typed_q[0], m_tdata[7:0]);
                        err_cnt++;
                    end
                    void'(typed_q.pop_front());
                end
                if (exp_b.ch != m_tdata[7:0])
                begin
                    $error("out_byte exp %h got %h", exp_b.ch, m_tdata[7:0]);
                    err_cnt++;
                end
                if (exp_b.drops != m_tdata[23:8])
                begin
                    $error("dropped_frames exp %0d got %0d", exp_b.drops, m_tdata[23:8]);
                    err_cnt++;
                end
                if (exp_b.lf_end != m_tlast)
                begin
                    $error("last exp %b got %b", exp_b.lf_end, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (!stall_en)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 9) > 2);
    end

    // Drive one input transaction, held until accepted; valid stays up for the caller
    task automatic send_item(logic cmd, logic [127:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(cmd, data);
        @(negedge clk);
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (line_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_div(logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        div_reg  = val;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            4: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return 32'($signed($urandom_range(0, 1310720)) - 655360);
        endcase
    endfunction

    stim_row_t rows [$];

    function automatic stim_row_t mk(logic cmd, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] c, logic [31:0] d);
        stim_row_t r;
        r.cmd = cmd;
        r.smp = '{a, b, c, d};
        r.n_want = -1;
        r.want = '{8'h0, 8'h0, 8'h0, 8'h0};
        return r;
    endfunction

    initial
    begin
        stim_row_t r;
        logic [127:0] pk;
        int burst;
        int sent;
        int lines;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = 16'd0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_TICK;
        m_tready = 1'b1;
        stall_en = 1'b0;
        err_cnt  = 0;
        div_reg  = 16'd1;
        prescale = 16'd0;
        snap_pending = 1'b0;
        drop_cnt = 16'd0;
        for (int i = 0; i < 4; i++)
            snap[i] = 32'd0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        r = mk(CMD_SERVICE, 0, 0, 0, 0);                          // nothing pending
        rows.push_back(r);
        rows.push_back(mk(CMD_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF));
        r = mk(CMD_SERVICE, 0, 0, 0, 0);
        r.n_want = 4;
        r.want = '{"9", "9", "9", "9"};                           // clamp positive
        rows.push_back(r);
        rows.push_back(mk(CMD_TICK, 32'hFFFF_FFE0, 32'h0000_0021, 32'h0001_0000,
                          32'hFFFE_8000));                        // negative rounds to zero
        rows.push_back(mk(CMD_TICK, 1, 2, 3, 4));                 // dropped
        rows.push_back(mk(CMD_TICK, 5, 6, 7, 8));                 // dropped
        r = mk(CMD_SERVICE, 0, 0, 0, 0);
        r.n_want = 2;
        r.want = '{"0", ".", "0", "0"};
        rows.push_back(r);
        rows.push_back(mk(CMD_TICK, 32'h0000_0083, 32'hFFFF_FF7D, 32'h270F_FFBE,
                          32'hD8F0_0042));
        rows.push_back(mk(CMD_SERVICE, 0, 0, 0, 0));
        rows.push_back(mk(CMD_TICK, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_8000,
                          32'hFFFF_8000));
        rows.push_back(mk(CMD_SERVICE, 0, 0, 0, 0));
        rows.push_back(mk(CMD_SERVICE, 0, 0, 0, 0));

        foreach (rows[k])
        begin
            for (int i = 0; i < rows[k].n_want; i++)
                typed_q.push_back(rows[k].want[i]);
            pk = {rows[k].smp[3], rows[k].smp[2], rows[k].smp[1], rows[k].smp[0]};
            send_item(rows[k].cmd, pk);
        end
        drain_idle();

        // Zero divider, then divider 3, then lowered below the prescaler
        write_div(16'd0);
        send_item(CMD_TICK, {4{32'h0001_2345}});
        send_item(CMD_SERVICE, '0);
        drain_idle();
        write_div(16'd3);
        send_item(CMD_TICK, {4{32'h0000_1111}});
        send_item(CMD_TICK, {4{32'h0000_2222}});
        drain_idle();
        write_div(16'd1);
        send_item(CMD_TICK, {4{32'h0000_3333}});
        send_item(CMD_SERVICE, '0);
        drain_idle();

        // Random phases at several divider settings
        stall_en = 1'b1;
        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_div(16'd1);
                1: write_div(16'd2);
                2: write_div(16'd0);
                3: write_div(16'hFFFF);
                default: write_div(16'd1);
            endcase
            lines = 0;
            while ((ph != 3 && lines < 15) || sent < 60 * (ph + 1))
            begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst; b++)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        if (snap_pending)
                            lines++;
                        send_item(CMD_SERVICE, {$urandom(), $urandom(), $urandom(),
                                                $urandom()});
                    end
                    else
                        send_item(CMD_TICK, {rand_sample(), rand_sample(),
                                             rand_sample(), rand_sample()});
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
            end
            // hold off until all output has arrived
            drain_idle();
        end

        drain_idle();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
